### src/rmq_pkg.sv
`default_nettype none
package rmq_pkg;

  // Element width and fixed-point format (Q2.14 at a width of 16).
  localparam int DW   = 16;
  localparam int FRAC = DW - 2;
  // Numerators are sums or differences of two elements.
  localparam int NW   = DW + 1;
  // Radicand and trace width: three elements plus one.
  localparam int SW   = DW + 3;
  // Root width and the width of the radicand shifted up by FRAC.
  localparam int RW   = DW;
  localparam int RADW = 2 * RW;

  // One root bit per square-root stage, one quotient bit per divider stage.
  localparam int SQ_STEPS  = RW;
  localparam int DIV_STEPS = DW;
  // Front register, root stages, divider setup, divider stages, output register.
  localparam int LATENCY   = SQ_STEPS + DIV_STEPS + 3;

  localparam logic signed [SW-1:0] ONE_S   = SW'(2 ** FRAC);
  localparam logic signed [DW-1:0] MAX_FIX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_FIX = {1'b1, {(DW-1){1'b0}}};

  // Which component takes r/2: an axis index, or the trace branch (w).
  typedef logic [1:0] sel_t;
  localparam sel_t SEL_X     = 2'd0;
  localparam sel_t SEL_Y     = 2'd1;
  localparam sel_t SEL_Z     = 2'd2;
  localparam sel_t SEL_TRACE = 2'd3;

  typedef struct packed {
    logic signed [DW-1:0] m00;
    logic signed [DW-1:0] m01;
    logic signed [DW-1:0] m02;
    logic signed [DW-1:0] m10;
    logic signed [DW-1:0] m11;
    logic signed [DW-1:0] m12;
    logic signed [DW-1:0] m20;
    logic signed [DW-1:0] m21;
    logic signed [DW-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [DW-1:0] quat_x;
    logic signed [DW-1:0] quat_y;
    logic signed [DW-1:0] quat_z;
    logic signed [DW-1:0] quat_w;
  } quat_t;

  // Data that rides alongside the root computation.
  typedef struct packed {
    sel_t                 sel;
    logic                 rz;
    logic signed [NW-1:0] na;
    logic signed [NW-1:0] nb;
    logic signed [NW-1:0] nc;
  } side_t;

  // One divider lane: magnitude long division with sign and overflow flags.
  typedef struct packed {
    logic          neg;
    logic          zero;
    logic          ov;
    logic [DW:0]   rem;
    logic [DW-1:0] lowb;
    logic [DW-1:0] q;
  } lane_t;

  typedef struct packed {
    sel_t          sel;
    logic          rz;
    logic [DW-1:0] half;
    logic [DW:0]   dvs;
    lane_t         la;
    lane_t         lb;
    lane_t         lc;
  } dst_t;

endpackage
`default_nettype wire

### src/rmq_front.sv
`default_nettype none
module rmq_front import rmq_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  mat_t            mat,
  output logic            valid_r,
  output logic [RADW-1:0] rad_r,
  output side_t           side_r
);

  sel_t                 i_sel;
  logic signed [DW-1:0] dii;
  logic signed [DW-1:0] mii, mjj, mkk, mjk, mkj, mij, mji, mik, mki;
  logic signed [SW-1:0] trace;
  logic signed [SW-1:0] s;
  logic [RADW-1:0]      rad_nxt;
  side_t                side_nxt;

  // Largest diagonal element, ties to the lower index.
  always_comb begin
    i_sel = SEL_X;
    if (mat.m00 < mat.m11) begin
      i_sel = SEL_Y;
    end
    dii = (i_sel == SEL_Y) ? mat.m11 : mat.m00;
    if (dii < mat.m22) begin
      i_sel = SEL_Z;
    end
  end

  // Pick the i, j, k elements for the chosen axis.
  always_comb begin
    unique case (i_sel)
      SEL_Y: begin
        mii = mat.m11; mjj = mat.m22; mkk = mat.m00;
        mjk = mat.m20; mkj = mat.m02;
        mij = mat.m12; mji = mat.m21;
        mik = mat.m10; mki = mat.m01;
      end
      SEL_Z: begin
        mii = mat.m22; mjj = mat.m00; mkk = mat.m11;
        mjk = mat.m01; mkj = mat.m10;
        mij = mat.m20; mji = mat.m02;
        mik = mat.m21; mki = mat.m12;
      end
      default: begin
        mii = mat.m00; mjj = mat.m11; mkk = mat.m22;
        mjk = mat.m12; mkj = mat.m21;
        mij = mat.m01; mji = mat.m10;
        mik = mat.m02; mki = mat.m20;
      end
    endcase
  end

  // Radicand and numerators for both branches.
  always_comb begin
    trace = SW'(mat.m00) + SW'(mat.m11) + SW'(mat.m22);
    if (trace > 0) begin
      s            = trace + ONE_S;
      side_nxt.sel = SEL_TRACE;
      side_nxt.na  = NW'(mat.m12) - NW'(mat.m21);
      side_nxt.nb  = NW'(mat.m20) - NW'(mat.m02);
      side_nxt.nc  = NW'(mat.m01) - NW'(mat.m10);
    end else begin
      s            = SW'(mii) - (SW'(mjj) + SW'(mkk)) + ONE_S;
      side_nxt.sel = i_sel;
      side_nxt.na  = NW'(mjk) - NW'(mkj);
      side_nxt.nb  = NW'(mij) + NW'(mji);
      side_nxt.nc  = NW'(mik) + NW'(mki);
    end
    // A non-positive radicand gives a zero root.
    side_nxt.rz = s[SW-1] || (s == '0);
    rad_nxt     = side_nxt.rz ? '0 : {1'b0, s[DW:0], {FRAC{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    side_r <= side_nxt;
  end

endmodule
`default_nettype wire

### src/rmq_sqrt.sv
`default_nettype none
module rmq_sqrt import rmq_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_in,
  input  logic [RADW-1:0] rad_in,
  input  side_t           side_in,
  output logic            valid_out,
  output logic [RW-1:0]   root_out,
  output side_t           side_out
);

  typedef struct packed {
    logic [RW+1:0]   rem;
    logic [RW-1:0]   root;
    logic [RADW-1:0] rad;
    side_t           side;
  } sq_t;

  sq_t            cur     [0:SQ_STEPS-1];
  sq_t            st_nxt  [1:SQ_STEPS];
  sq_t            st_r    [1:SQ_STEPS];
  logic [RW+3:0]  cand    [0:SQ_STEPS-1];
  logic [RW+3:0]  trial   [0:SQ_STEPS-1];
  logic [RW+3:0]  diff    [0:SQ_STEPS-1];
  logic [SQ_STEPS:1] v_r;

  // One root bit per stage: bring down two radicand bits, try 4*root+1.
  always_comb begin
    cur[0].rem  = '0;
    cur[0].root = '0;
    cur[0].rad  = rad_in;
    cur[0].side = side_in;
    for (int e = 1; e < SQ_STEPS; e++) begin
      cur[e] = st_r[e];
    end
    for (int e = 0; e < SQ_STEPS; e++) begin
      cand[e]  = {cur[e].rem, cur[e].rad[RADW-1 -: 2]};
      trial[e] = {2'b00, cur[e].root, 2'b01};
      diff[e]  = cand[e] - trial[e];
      st_nxt[e+1].rad  = cur[e].rad << 2;
      st_nxt[e+1].side = cur[e].side;
      if (cand[e] >= trial[e]) begin
        st_nxt[e+1].rem  = diff[e][RW+1:0];
        st_nxt[e+1].root = {cur[e].root[RW-2:0], 1'b1};
      end else begin
        st_nxt[e+1].rem  = cand[e][RW+1:0];
        st_nxt[e+1].root = {cur[e].root[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r[1] <= valid_in;
      for (int e = 2; e <= SQ_STEPS; e++) begin
        v_r[e] <= v_r[e-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 1; e <= SQ_STEPS; e++) begin
      st_r[e] <= st_nxt[e];
    end
  end

  assign valid_out = v_r[SQ_STEPS];
  assign root_out  = st_r[SQ_STEPS].root;
  assign side_out  = st_r[SQ_STEPS].side;

endmodule
`default_nettype wire

### src/rmq_div.sv
`default_nettype none
module rmq_div import rmq_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_in,
  input  logic [RW-1:0] root_in,
  input  side_t         side_in,
  output logic          valid_out,
  output dst_t          dst_out
);

  dst_t              st_nxt [0:DIV_STEPS];
  dst_t              st_r   [0:DIV_STEPS];
  logic [DIV_STEPS:0] v_r;

  // Magnitude, sign and overflow test of one numerator against 2r.
  function automatic lane_t lane_init(logic signed [NW-1:0] n, logic [DW:0] dvs);
    logic [NW-1:0] mag;
    lane_t         o;
    mag    = n[NW-1] ? (~n + 1'b1) : n;
    o.neg  = n[NW-1];
    o.zero = (n == '0);
    // The quotient fits DW bits only if the upper dividend is below the divisor.
    o.rem  = (DW+1)'(mag[NW-1:DW-FRAC]);
    o.ov   = ((DW+1)'(mag[NW-1:DW-FRAC]) >= dvs);
    o.lowb = {mag[DW-FRAC-1:0], {FRAC{1'b0}}};
    o.q    = '0;
    return o;
  endfunction

  // One restoring division step.
  function automatic lane_t lane_step(lane_t l, logic [DW:0] dvs);
    logic [DW+1:0] cand;
    logic [DW+1:0] diff;
    logic          qbit;
    lane_t         o;
    o    = l;
    cand = {l.rem, l.lowb[DW-1]};
    diff = cand - {1'b0, dvs};
    qbit = (cand >= {1'b0, dvs});
    o.rem  = qbit ? diff[DW:0] : cand[DW:0];
    o.q    = {l.q[DW-2:0], qbit};
    o.lowb = l.lowb << 1;
    return o;
  endfunction

  // Setup stage, then one quotient bit per stage on all three lanes.
  always_comb begin
    st_nxt[0].sel  = side_in.sel;
    st_nxt[0].rz   = side_in.rz;
    st_nxt[0].half = root_in >> 1;
    st_nxt[0].dvs  = {root_in, 1'b0};
    st_nxt[0].la   = lane_init(side_in.na, {root_in, 1'b0});
    st_nxt[0].lb   = lane_init(side_in.nb, {root_in, 1'b0});
    st_nxt[0].lc   = lane_init(side_in.nc, {root_in, 1'b0});
    for (int e = 1; e <= DIV_STEPS; e++) begin
      st_nxt[e]    = st_r[e-1];
      st_nxt[e].la = lane_step(st_r[e-1].la, st_r[e-1].dvs);
      st_nxt[e].lb = lane_step(st_r[e-1].lb, st_r[e-1].dvs);
      st_nxt[e].lc = lane_step(st_r[e-1].lc, st_r[e-1].dvs);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r[0] <= valid_in;
      for (int e = 1; e <= DIV_STEPS; e++) begin
        v_r[e] <= v_r[e-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e <= DIV_STEPS; e++) begin
      st_r[e] <= st_nxt[e];
    end
  end

  assign valid_out = v_r[DIV_STEPS];
  assign dst_out   = st_r[DIV_STEPS];

endmodule
`default_nettype wire

### src/rmq_back.sv
`default_nettype none
module rmq_back import rmq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  valid_in,
  input  dst_t  dst_in,
  output logic  out_valid_r,
  output quat_t out_quat_r
);

  logic signed [DW-1:0] qa, qb, qc, qh;
  quat_t                quat_nxt;

  // Signed, saturated quotient; a zero root gives full scale by sign, or zero for a zero numerator.
  function automatic logic signed [DW-1:0] lane_sat(lane_t l, logic rz);
    logic signed [DW-1:0] v;
    if (rz) begin
      v = l.zero ? '0 : (l.neg ? MIN_FIX : MAX_FIX);
    end else if (!l.neg) begin
      v = (l.ov || l.q[DW-1]) ? MAX_FIX : l.q;
    end else if (l.ov || (l.q[DW-1] && (l.q[DW-2:0] != '0))) begin
      v = MIN_FIX;
    end else begin
      v = ~l.q + 1'b1;
    end
    return v;
  endfunction

  // Place r/2 and the three quotients by the chosen axis.
  always_comb begin
    qa = lane_sat(dst_in.la, dst_in.rz);
    qb = lane_sat(dst_in.lb, dst_in.rz);
    qc = lane_sat(dst_in.lc, dst_in.rz);
    qh = dst_in.half;
    unique case (dst_in.sel)
      SEL_X: begin
        quat_nxt = '{quat_x: qh, quat_y: qb, quat_z: qc, quat_w: qa};
      end
      SEL_Y: begin
        quat_nxt = '{quat_x: qc, quat_y: qh, quat_z: qb, quat_w: qa};
      end
      SEL_Z: begin
        quat_nxt = '{quat_x: qb, quat_y: qc, quat_z: qh, quat_w: qa};
      end
      default: begin
        quat_nxt = '{quat_x: qa, quat_y: qb, quat_z: qc, quat_w: qh};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    out_quat_r <= quat_nxt;
  end

endmodule
`default_nettype wire

### src/rotation_matrix_to_quaternion_unit.sv
// Channel   Ports                   Handshake
// -------   ---------------------   ------------------------------------------
// request   start, busy, in_mat    taken at a clock edge with start high, busy low
// result    out_valid, out_quat     one-cycle strobe, no back-pressure
//
// A new matrix is taken every cycle; busy is always low.
// Each result passes through one front register,
// 16 square-root stages (one root bit each), a divider setup stage,
// 16 divider stages (one quotient bit each) and the output register.
// Synchronous active-low reset clears the valid bits of every stage.
// The pipeline never stalls, since the receiver cannot hold results off.
`default_nettype none
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  mat_t  in_mat,
  output logic  out_valid,
  output quat_t out_quat
);

  logic            f_valid;
  logic [RADW-1:0] f_rad;
  side_t           f_side;
  logic            s_valid;
  logic [RW-1:0]   s_root;
  side_t           s_side;
  logic            d_valid;
  dst_t            d_dst;

  assign busy = 1'b0;

  // Branch choice, radicand and numerators.
  rmq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .mat      (in_mat),
    .valid_r  (f_valid),
    .rad_r    (f_rad),
    .side_r   (f_side)
  );

  // Pipelined integer square root.
  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (f_valid),
    .rad_in    (f_rad),
    .side_in   (f_side),
    .valid_out (s_valid),
    .root_out  (s_root),
    .side_out  (s_side)
  );

  // Three pipelined dividers by 2r.
  rmq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (s_valid),
    .root_in   (s_root),
    .side_in   (s_side),
    .valid_out (d_valid),
    .dst_out   (d_dst)
  );

  // Saturation and component routing.
  rmq_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_in    (d_valid),
    .dst_in      (d_dst),
    .out_valid_r (out_valid),
    .out_quat_r  (out_quat)
  );

endmodule
`default_nettype wire

### src/rmq_check.sv
`default_nettype none
module rmq_check import rmq_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  start,
  input logic  busy,
  input mat_t  in_mat,
  input logic  out_valid,
  input quat_t out_quat
);

  logic ident;

  // The identity matrix maps to the unit scalar quaternion.
  assign ident = (in_mat.m00 == DW'(2 ** FRAC)) && (in_mat.m11 == DW'(2 ** FRAC)) &&
                 (in_mat.m22 == DW'(2 ** FRAC)) && (in_mat.m01 == '0) &&
                 (in_mat.m02 == '0) && (in_mat.m10 == '0) && (in_mat.m12 == '0) &&
                 (in_mat.m20 == '0) && (in_mat.m21 == '0);

  // The unit always takes requests.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // Every result stems from a request a fixed latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching request");

  // Identity input gives w = 1.0 and a zero vector part.
  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && !busy && ident, LATENCY)) |->
    (out_quat.quat_w == DW'(2 ** FRAC)) && (out_quat.quat_x == '0) &&
    (out_quat.quat_y == '0) && (out_quat.quat_z == '0))
    else $error("identity matrix gave wrong quaternion");

  // Reset empties the pipeline.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_check u_check (.*);
`default_nettype wire
